>>> hdl/owdm_pkg.sv
// ----------------------------------------------------------------------------
// owdm_pkg: omni wheel drive mixer package
// Request types, CORDIC constants and arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package owdm_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int DUTY_MAX_DEF        = 255;
  localparam int CORDIC_STEPS        = 24;
  localparam int STEP_W              = 5;
  localparam int ZW                  = 35;
  localparam int XW                  = 32;
  localparam int RW                  = 18;
  localparam int QW                  = 17;

  localparam logic signed [ZW-1:0] PI4_Q30     = 35'sd843314857;
  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_Q30    = 32'sh26DD3B6A;

  typedef struct packed {
    logic signed [15:0] heading;
    logic [6:0]         speed_percent;
  } in_req_t;

  typedef struct packed {
    logic       m1_fwd;
    logic       m1_rev;
    logic [7:0] m1_duty;
    logic       m2_fwd;
    logic       m2_rev;
    logic [7:0] m2_duty;
    logic       m3_fwd;
    logic       m3_rev;
    logic [7:0] m3_duty;
    logic       m4_fwd;
    logic       m4_rev;
    logic [7:0] m4_duty;
  } out_req_t;

  // CORDIC stage payload
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
    logic [6:0]           pct;
  } cord_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 35'sh3243F6A8;
      5'd1:  v = 35'sh1DAC6705;
      5'd2:  v = 35'sh0FADBAFC;
      5'd3:  v = 35'sh07F56EA6;
      5'd4:  v = 35'sh03FEAB76;
      5'd5:  v = 35'sh01FFD55B;
      5'd6:  v = 35'sh00FFFAAA;
      5'd7:  v = 35'sh007FFF55;
      5'd8:  v = 35'sh003FFFEA;
      5'd9:  v = 35'sh001FFFFD;
      5'd10: v = 35'sh000FFFFF;
      5'd11: v = 35'sh0007FFFF;
      5'd12: v = 35'sh0003FFFF;
      5'd13: v = 35'sh0001FFFF;
      5'd14: v = 35'sh0000FFFF;
      5'd15: v = 35'sh00007FFF;
      5'd16: v = 35'sh00003FFF;
      5'd17: v = 35'sh00001FFF;
      5'd18: v = 35'sh00000FFF;
      5'd19: v = 35'sh000007FF;
      5'd20: v = 35'sh000003FF;
      5'd21: v = 35'sh000001FF;
      5'd22: v = 35'sh000000FF;
      5'd23: v = 35'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/omni_wheel_drive_mixer_core.sv
// ----------------------------------------------------------------------------
// omni_wheel_drive_mixer_core: four-wheel omni drive mixer
// Heading and speed in, four signed wheel drives out, via a CORDIC cell
// chain and a divider cell chain.
// ----------------------------------------------------------------------------
// Channel  Ports                 Payload
// in       in_valid / in_stall   in_data  (in_req_t)
// out      out_valid / out_stall out_data (out_req_t)
//
// One request per cycle unless out_stall holds the pipeline.
// The whole pipeline advances when the output register is empty or drains.
// Synchronous active-low reset clears valid bits only.
// in_stall follows out_stall and the output register occupancy.
`timescale 1ns / 1ps
`default_nettype none
module omni_wheel_drive_mixer_core
  import owdm_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int DUTY_MAX        = DUTY_MAX_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_req_t     out_data
);

  localparam int NDIV = QW;
  localparam int DW   = 8;
  // ceil(2^26 / 100), exact floor(v / 100) for v < 2^20
  localparam logic [19:0] RECIP_100 = 20'd671089;

  logic en;
  logic out_vld_r;
  assign en       = !out_vld_r || !out_stall;
  assign in_stall = !en;

  // angle setup stage
  logic signed [ZW-1:0] z0, z1;
  logic fl;
  cord_t s0_nxt, s0_r;
  logic  s0_vld_r;

  always_comb begin
    z0 = (ZW'(in_data.heading) <<< (30 - ANGLE_FRAC_BITS)) - PI4_Q30;
    if (z0 > PI_Q30) begin
      z1 = z0 - TWO_PI_Q30;
    end else if (z0 < -PI_Q30) begin
      z1 = z0 + TWO_PI_Q30;
    end else begin
      z1 = z0;
    end
    fl = 1'b0;
    if (z1 > HALF_PI_Q30) begin
      z1 = z1 - PI_Q30;
      fl = 1'b1;
    end else if (z1 < -HALF_PI_Q30) begin
      z1 = z1 + PI_Q30;
      fl = 1'b1;
    end
    s0_nxt.x    = GAIN_Q30;
    s0_nxt.y    = '0;
    s0_nxt.z    = z1;
    s0_nxt.flip = fl;
    s0_nxt.pct  = (in_data.speed_percent > 7'd100) ? 7'd100 : in_data.speed_percent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  cord_t cd [0:CORDIC_STEPS];
  logic  cv [0:CORDIC_STEPS];
  assign cd[0] = s0_r;
  assign cv[0] = s0_vld_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cord
    owdm_cordic_cell #(.STEP(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(cv[g]), .d_in(cd[g]),
      .vld_out(cv[g+1]), .d_out(cd[g+1])
    );
  end

  // rounding and divider seed
  logic signed [XW:0] xf, yf, cr, sr;
  logic [RW-1:0] mc, ms, am;
  cord_t ce;
  always_comb begin
    ce = cd[CORDIC_STEPS];
    xf = ce.flip ? -(XW+1)'(ce.x) : (XW+1)'(ce.x);
    yf = ce.flip ? -(XW+1)'(ce.y) : (XW+1)'(ce.y);
    cr = (xf + 33'sd8192) >>> 14;
    sr = (yf + 33'sd8192) >>> 14;
    mc = cr[XW] ? RW'(-cr) : RW'(cr);
    ms = sr[XW] ? RW'(-sr) : RW'(sr);
    am = (mc > ms) ? mc : ms;
    if (am == '0) begin
      am = RW'(1);
    end
  end

  logic [RW-1:0] da [0:NDIV];
  logic [RW-1:0] drc [0:NDIV];
  logic [RW-1:0] drs [0:NDIV];
  logic [QW-1:0] dqc [0:NDIV];
  logic [QW-1:0] dqs [0:NDIV];
  logic          dnc [0:NDIV];
  logic          dns [0:NDIV];
  logic [6:0]    dp  [0:NDIV];
  logic          dv  [0:NDIV];

  assign da[0]  = am;
  assign drc[0] = mc;
  assign drs[0] = ms;
  assign dqc[0] = '0;
  assign dqs[0] = '0;
  assign dnc[0] = cr[XW];
  assign dns[0] = sr[XW];
  assign dp[0]  = ce.pct;
  assign dv[0]  = cv[CORDIC_STEPS];

  // cell 0 resolves quotient bit 16 (|c| >= a) without shifting
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    owdm_div_cell #(.FIRST(g == 0)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .vld_in(dv[g]),
      .a_in(da[g]), .rc_in(drc[g]), .rs_in(drs[g]),
      .qc_in(dqc[g]), .qs_in(dqs[g]),
      .nc_in(dnc[g]), .ns_in(dns[g]), .pct_in(dp[g]),
      .vld_out(dv[g+1]), .a_out(da[g+1]), .rc_out(drc[g+1]), .rs_out(drs[g+1]),
      .qc_out(dqc[g+1]), .qs_out(dqs[g+1]),
      .nc_out(dnc[g+1]), .ns_out(dns[g+1]), .pct_out(dp[g+1])
    );
  end

  // scale stage: v = floor(q * DUTY_MAX * pct / 65536), duty = floor(v / 100)
  logic [QW-1:0] qcf, qsf;
  logic [19:0]   scl;
  logic [36:0]   pcf, psf;
  logic [19:0]   vc_r, vs_r;
  logic          nc_r, ns_r, sv_r;

  always_comb begin
    qcf = dqc[NDIV];
    qsf = dqs[NDIV];
    scl = 20'(DUTY_MAX) * 20'(dp[NDIV]);
    pcf = 37'(qcf) * 37'(scl);
    psf = 37'(qsf) * 37'(scl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (en) begin
      sv_r <= dv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vc_r <= pcf[35:16];
      vs_r <= psf[35:16];
      nc_r <= dnc[NDIV];
      ns_r <= dns[NDIV];
    end
  end

  logic [39:0] pc, ps;
  logic [13:0] dc, ds;
  out_req_t o_nxt, o_r;

  always_comb begin
    pc = 40'(vc_r) * 40'(RECIP_100);
    ps = 40'(vs_r) * 40'(RECIP_100);
    dc = pc[39:26];
    ds = ps[39:26];
    o_nxt.m1_duty = DW'(dc);
    o_nxt.m3_duty = DW'(dc);
    o_nxt.m2_duty = DW'(ds);
    o_nxt.m4_duty = DW'(ds);
    o_nxt.m1_fwd = (dc != 0) && nc_r;
    o_nxt.m1_rev = (dc != 0) && !nc_r;
    o_nxt.m3_fwd = (dc != 0) && !nc_r;
    o_nxt.m3_rev = (dc != 0) && nc_r;
    o_nxt.m2_fwd = (ds != 0) && ns_r;
    o_nxt.m2_rev = (ds != 0) && !ns_r;
    o_nxt.m4_fwd = (ds != 0) && !ns_r;
    o_nxt.m4_rev = (ds != 0) && ns_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = o_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.m1_fwd && out_data.m1_rev) &&
                  !(out_data.m2_fwd && out_data.m2_rev))
    else $error("wheel driven both ways");
  a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.m3_duty == 8'd0 |-> !out_data.m3_fwd && !out_data.m3_rev)
    else $error("direction set with zero duty");

endmodule
`default_nettype wire

>>> hdl/owdm_cordic_cell.sv
// ----------------------------------------------------------------------------
// owdm_cordic_cell: one CORDIC rotation stage
// Rotates the vector one micro-step and hands it to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module owdm_cordic_cell
  import owdm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  vld_in,
  input  wire cord_t d_in,
  output logic       vld_out,
  output cord_t      d_out
);

  localparam logic [STEP_W-1:0] STEP_IDX = STEP_W'(STEP);

  logic  vld_r;
  cord_t d_r, d_nxt;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;

  always_comb begin
    dx = d_in.y >>> STEP;
    dy = d_in.x >>> STEP;
    at = atan_q30(STEP_IDX);
    d_nxt = d_in;
    if (d_in.z >= 0) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - at;
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_out = vld_r;
  assign d_out   = d_r;

endmodule
`default_nettype wire

>>> hdl/owdm_div_cell.sv
// ----------------------------------------------------------------------------
// owdm_div_cell: one restoring divider step for both ratios
// Produces one quotient bit of |c|/a and |s|/a per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module owdm_div_cell
  import owdm_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_in,
  input  wire logic [RW-1:0] a_in,
  input  wire logic [RW-1:0] rc_in,
  input  wire logic [RW-1:0] rs_in,
  input  wire logic [QW-1:0] qc_in,
  input  wire logic [QW-1:0] qs_in,
  input  wire logic          nc_in,
  input  wire logic          ns_in,
  input  wire logic [6:0]    pct_in,
  output logic               vld_out,
  output logic [RW-1:0]      a_out,
  output logic [RW-1:0]      rc_out,
  output logic [RW-1:0]      rs_out,
  output logic [QW-1:0]      qc_out,
  output logic [QW-1:0]      qs_out,
  output logic               nc_out,
  output logic               ns_out,
  output logic [6:0]         pct_out
);

  logic vld_r;
  logic [RW:0] tc, ts;
  logic [RW-1:0] rc_nxt, rs_nxt;
  logic bc, bs;

  // first cell compares the unshifted dividend (quotient bit 16)
  always_comb begin
    tc = FIRST ? {1'b0, rc_in} : {rc_in, 1'b0};
    ts = FIRST ? {1'b0, rs_in} : {rs_in, 1'b0};
    bc = tc >= {1'b0, a_in};
    bs = ts >= {1'b0, a_in};
    rc_nxt = bc ? RW'(tc - {1'b0, a_in}) : RW'(tc);
    rs_nxt = bs ? RW'(ts - {1'b0, a_in}) : RW'(ts);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out   <= a_in;
      rc_out  <= rc_nxt;
      rs_out  <= rs_nxt;
      qc_out  <= {qc_in[QW-2:0], bc};
      qs_out  <= {qs_in[QW-2:0], bs};
      nc_out  <= nc_in;
      ns_out  <= ns_in;
      pct_out <= pct_in;
    end
  end

  assign vld_out = vld_r;

endmodule
`default_nettype wire
